@@ rtl/edpa_pkg.sv @@
// Shared types and constants for the event divider with phase alignment.
package edpa_pkg;

    localparam int DIV_W    = 17;
    localparam int IDX_W    = 64;
    localparam int TOTAL_W  = 32;
    localparam int PHASE_W  = 16;
    localparam int STEP_W   = $clog2(IDX_W);

    localparam logic [DIV_W-1:0]  DIV_MAX   = 17'd65536;
    localparam logic [DIV_W-1:0]  DIV_SMALL = 17'd4;
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(IDX_W - 1);

    typedef enum logic [1:0] {
        FUNC_GRID      = 2'd0,
        FUNC_ALIGN_REQ = 2'd1,
        FUNC_STOP      = 2'd2,
        FUNC_START     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        OUT_NONE     = 2'd0,
        OUT_ALIGNED  = 2'd1,
        OUT_DEFERRED = 2'd2
    } t_outcome;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    typedef struct packed {
        logic step;
        logic div_go;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_status;

endpackage

@@ rtl/edpa_if.sv @@
// Valid/ready channel interfaces for event items and result items.
interface edpa_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] grid_index;

    modport source (output valid, output func, output grid_index, input ready);
    modport sink (input valid, input func, input grid_index, output ready);
endinterface

interface edpa_res_if;
    logic        valid;
    logic        ready;
    logic        led_level;
    logic [15:0] phase_count;
    logic        align_pending;
    logic [1:0]  align_outcome;
    logic [31:0] aligned_total;
    logic [31:0] deferred_total;
    logic [63:0] last_aligned_index;

    modport source (
        output valid, output led_level, output phase_count, output align_pending,
        output align_outcome, output aligned_total, output deferred_total,
        output last_aligned_index, input ready
    );
    modport sink (
        input valid, input led_level, input phase_count, input align_pending,
        input align_outcome, input aligned_total, input deferred_total,
        input last_aligned_index, output ready
    );
endinterface

@@ rtl/edpa_divider.sv @@
// Restoring divider: 64-bit index by 17-bit divisor, one quotient bit per cycle.
module edpa_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [edpa_pkg::IDX_W-1:0]   i_dividend,
    input  logic [edpa_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [edpa_pkg::DIV_W-1:0]   o_rem,
    output logic                         o_q_lsb
);

    logic                         r_busy;
    logic                         r_done;
    logic [edpa_pkg::STEP_W-1:0]  r_cnt;
    logic [edpa_pkg::IDX_W-1:0]   r_dvd;
    logic [edpa_pkg::DIV_W-1:0]   r_dsr;
    logic [edpa_pkg::DIV_W-1:0]   r_rem;
    logic                         r_q;

    logic [edpa_pkg::DIV_W:0]     w_trial;
    logic                         w_ge;
    logic [edpa_pkg::DIV_W-1:0]   n_rem;

    // The partial remainder stays below the divisor, so the trial fits in one extra bit.
    assign w_trial = {r_rem, r_dvd[edpa_pkg::IDX_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign n_rem   = w_ge ? edpa_pkg::DIV_W'(w_trial - {1'b0, r_dsr})
                          : w_trial[edpa_pkg::DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == edpa_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_q   <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[edpa_pkg::IDX_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= w_ge;
        end
    end

    assign o_done  = r_done;
    assign o_rem   = r_rem;
    assign o_q_lsb = r_q;

endmodule

@@ rtl/edpa_datapath.sv @@
// Divider state, alignment counters and the shared divide unit.
module edpa_datapath #(
    parameter int CounterBits = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [edpa_pkg::DIV_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_func,
    input  logic [edpa_pkg::IDX_W-1:0]    i_grid_index,
    input  edpa_pkg::t_cmd                i_cmd,
    output edpa_pkg::t_status             o_status,
    output logic                          o_led_level,
    output logic [edpa_pkg::PHASE_W-1:0]  o_phase_count,
    output logic                          o_align_pending,
    output logic [1:0]                    o_align_outcome,
    output logic [edpa_pkg::TOTAL_W-1:0]  o_aligned_total,
    output logic [edpa_pkg::TOTAL_W-1:0]  o_deferred_total,
    output logic [edpa_pkg::IDX_W-1:0]    o_last_aligned_index
);

    localparam int CmpW = (CounterBits > edpa_pkg::DIV_W) ? CounterBits : edpa_pkg::DIV_W;
    localparam int WinW = edpa_pkg::DIV_W + 2;

    logic [edpa_pkg::DIV_W-1:0]    r_divisor, n_divisor;
    logic [CounterBits-1:0]        r_counter, n_counter;
    logic                          r_led, n_led;
    logic                          r_pending, n_pending;
    logic [edpa_pkg::TOTAL_W-1:0]  r_aligned, n_aligned;
    logic [edpa_pkg::TOTAL_W-1:0]  r_deferred, n_deferred;
    logic [edpa_pkg::IDX_W-1:0]    r_last, n_last;
    logic [edpa_pkg::IDX_W-1:0]    r_idx;
    edpa_pkg::t_outcome            r_outcome, n_outcome;

    logic                          w_div_done;
    logic [edpa_pkg::DIV_W-1:0]    w_rem;
    logic                          w_q_lsb;
    logic                          w_wrap;
    logic [WinW-1:0]               w_three_n;
    logic                          w_outside;
    logic                          w_take;

    edpa_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (i_grid_index),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem),
        .o_q_lsb    (w_q_lsb)
    );

    // A counter left above the top by a divisor change wraps on the next grid event.
    assign w_wrap = (CmpW'(r_counter) >= CmpW'(r_divisor - 1'b1));

    // Unless n < 4, alignment waits while the phase sits outside the middle half of the period.
    assign w_three_n = (WinW'(r_divisor) << 1) + WinW'(r_divisor);
    assign w_outside = (w_rem < (r_divisor >> 2)) || (WinW'(w_rem) > (w_three_n >> 2));
    assign w_take    = (r_divisor < edpa_pkg::DIV_SMALL) || !w_outside;

    assign o_status.need_div = (edpa_pkg::t_func'(i_func) == edpa_pkg::FUNC_GRID)
                               && (r_divisor != '0) && r_pending;
    assign o_status.div_done = w_div_done;

    always_comb begin
        n_divisor  = r_divisor;
        n_counter  = r_counter;
        n_led      = r_led;
        n_pending  = r_pending;
        n_aligned  = r_aligned;
        n_deferred = r_deferred;
        n_last     = r_last;
        n_outcome  = r_outcome;

        if (i_cfg_we && (i_cfg_data <= edpa_pkg::DIV_MAX)) begin
            n_divisor = i_cfg_data;
            if (i_cfg_data == '0) begin
                n_led     = 1'b0;
                n_counter = '0;
                n_pending = 1'b0;
            end
        end

        if (i_cmd.step) begin
            n_outcome = edpa_pkg::OUT_NONE;
            unique case (edpa_pkg::t_func'(i_func))
                edpa_pkg::FUNC_GRID: begin
                    if (r_divisor != '0) begin
                        if (w_wrap) begin
                            n_counter = '0;
                            n_led     = ~r_led;
                        end else begin
                            n_counter = r_counter + 1'b1;
                        end
                    end
                end
                edpa_pkg::FUNC_ALIGN_REQ: begin
                    n_pending = 1'b1;
                end
                edpa_pkg::FUNC_STOP: begin
                    n_led = 1'b0;
                end
                edpa_pkg::FUNC_START: begin
                    if (r_divisor != '0) begin
                        n_counter = '0;
                        n_led     = 1'b0;
                        n_pending = 1'b1;
                    end
                end
            endcase
        end

        if (i_cmd.finish) begin
            if (w_take) begin
                // Below four events per toggle the phase is forced to zero.
                n_counter = (r_divisor < edpa_pkg::DIV_SMALL) ? '0 : CounterBits'(w_rem);
                n_led     = w_q_lsb;
                n_last    = r_idx;
                n_aligned = r_aligned + 1'b1;
                n_pending = 1'b0;
                n_outcome = edpa_pkg::OUT_ALIGNED;
            end else begin
                n_deferred = r_deferred + 1'b1;
                n_outcome  = edpa_pkg::OUT_DEFERRED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor  <= '0;
            r_counter  <= '0;
            r_led      <= 1'b0;
            r_pending  <= 1'b0;
            r_aligned  <= '0;
            r_deferred <= '0;
            r_last     <= '0;
            r_outcome  <= edpa_pkg::OUT_NONE;
        end else begin
            r_divisor  <= n_divisor;
            r_counter  <= n_counter;
            r_led      <= n_led;
            r_pending  <= n_pending;
            r_aligned  <= n_aligned;
            r_deferred <= n_deferred;
            r_last     <= n_last;
            r_outcome  <= n_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_idx <= i_grid_index;
        end
    end

    assign o_led_level          = r_led;
    assign o_phase_count        = edpa_pkg::PHASE_W'(r_counter);
    assign o_align_pending      = r_pending;
    assign o_align_outcome      = r_outcome;
    assign o_aligned_total      = r_aligned;
    assign o_deferred_total     = r_deferred;
    assign o_last_aligned_index = r_last;

endmodule

@@ rtl/edpa_ctrl.sv @@
// Controller: sequences each transaction and holds the result valid flag.
module edpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  edpa_pkg::t_status  i_status,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output edpa_pkg::t_cmd     o_cmd
);

    edpa_pkg::t_state  r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;
    logic              w_load;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            edpa_pkg::S_IDLE: begin
                if (w_accept && i_status.need_div) begin
                    n_state = edpa_pkg::S_DIV;
                end
            end
            edpa_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = edpa_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.div_go  = 1'b0;
        o_cmd.finish  = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            edpa_pkg::S_IDLE: begin
                // A waiting result may leave on the same edge a new transaction enters.
                o_in_ready   = !r_out_valid || i_out_ready;
                o_cmd.step   = w_accept;
                o_cmd.div_go = w_accept && i_status.need_div;
                w_load       = w_accept && !i_status.need_div;
            end
            edpa_pkg::S_DIV: begin
                o_cmd.finish = i_status.div_done;
                w_load       = i_status.div_done;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= edpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/event_divider_phase_align.sv @@
// Event divider with phase alignment: most transactions have their result registered for the next cycle.
// A grid event with an alignment request pending and a nonzero divisor first runs through
// the bit-serial divider that forms index mod n and bit 0 of index/n, then the finish step.
// No new transaction enters until such a grid event has finished.
// A new transaction is accepted on the edge that hands over the previous result.
// Reset (i_rst_n low, synchronous) clears the divisor, counter, LED, request and totals.
module event_divider_phase_align #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [edpa_pkg::DIV_W-1:0]  i_cfg_data,
    edpa_evt_if.sink                    i_evt,
    edpa_res_if.source                  o_res
);

    edpa_pkg::t_cmd     w_cmd;
    edpa_pkg::t_status  w_status;

    edpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    edpa_datapath #(
        .CounterBits (COUNTER_BITS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_func               (i_evt.func),
        .i_grid_index         (i_evt.grid_index),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .o_led_level          (o_res.led_level),
        .o_phase_count        (o_res.phase_count),
        .o_align_pending      (o_res.align_pending),
        .o_align_outcome      (o_res.align_outcome),
        .o_aligned_total      (o_res.aligned_total),
        .o_deferred_total     (o_res.deferred_total),
        .o_last_aligned_index (o_res.last_aligned_index)
    );

    // Once a divide starts, no transaction may enter until it finishes.
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready && w_status.need_div) |=> !i_evt.ready)
        else $error("transaction accepted during a divide");

    // A completed alignment always clears the request.
    a_aligned_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.align_outcome == edpa_pkg::OUT_ALIGNED)) |-> !o_res.align_pending)
        else $error("request still pending after alignment");

    // The deferral total moves only together with a deferred outcome.
    a_defer_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (o_res.deferred_total != $past(o_res.deferred_total)))
            |-> (o_res.align_outcome == edpa_pkg::OUT_DEFERRED))
        else $error("deferral total changed without a deferred outcome");

endmodule
